/* rtl/dgt_pkg.sv */
// Shared constants for the depth grid triangulator: field widths, register
// indexes, register reset values and result slot codes.
// No dependencies.
`timescale 1ns / 1ps

package dgt_pkg;

  // Field and state widths
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int DEPTH_BITS = 16;
  localparam int INDEX_BITS = 24;
  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 12;
  localparam int WCFG_BITS  = 11;
  localparam int HCFG_BITS  = 13;
  localparam int REG_BITS   = 3;
  localparam int DATA_BITS  = 16;

  // Configuration register indexes
  localparam logic [REG_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_BITS-1:0] REG_MIN_DEPTH    = 3'd2;
  localparam logic [REG_BITS-1:0] REG_MAX_DEPTH    = 3'd3;
  localparam logic [REG_BITS-1:0] REG_EDGE_LIMIT   = 3'd4;

  // Register values after reset
  localparam logic [WCFG_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HCFG_BITS-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [DEPTH_BITS-1:0] RST_MIN_DEPTH    = 16'd0;
  localparam logic [DEPTH_BITS-1:0] RST_MAX_DEPTH    = 16'd65535;
  localparam logic [DEPTH_BITS-1:0] RST_EDGE_LIMIT   = 16'd655;

  // Result kinds
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  // Result slots of one pixel, one-hot, emitted lowest first
  localparam logic [2:0] SLOT_VERTEX = 3'b001;
  localparam logic [2:0] SLOT_ACD    = 3'b010;
  localparam logic [2:0] SLOT_ADB    = 3'b100;

endpackage

/* rtl/dgt_pixel_if.sv */
// Pixel request channel: valid/ready handshake with depth and mask bit.
// Depends on dgt_pkg.
`timescale 1ns / 1ps

interface dgt_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [dgt_pkg::DEPTH_BITS-1:0]  depth_value;
  logic                            in_mask;

  modport source (output valid, output depth_value, output in_mask, input ready);
  modport sink   (input valid, input depth_value, input in_mask, output ready);
endinterface

/* rtl/dgt_result_if.sv */
// Result channel: valid/ready handshake carrying vertex and face records.
// Depends on dgt_pkg.
`timescale 1ns / 1ps

interface dgt_result_if;
  logic                            valid;
  logic                            ready;
  logic                            item_kind;
  logic [dgt_pkg::INDEX_BITS-1:0]  index_a;
  logic [dgt_pkg::INDEX_BITS-1:0]  index_b;
  logic [dgt_pkg::INDEX_BITS-1:0]  index_c;
  logic [dgt_pkg::COL_BITS-1:0]    pixel_col;
  logic [dgt_pkg::ROW_BITS-1:0]    pixel_row;
  logic [dgt_pkg::DEPTH_BITS-1:0]  depth_out;
  logic                            run_last;

  modport source (output valid, output item_kind, output index_a, output index_b,
                  output index_c, output pixel_col, output pixel_row,
                  output depth_out, output run_last, input ready);
  modport sink   (input valid, input item_kind, input index_a, input index_b,
                  input index_c, input pixel_col, input pixel_row,
                  input depth_out, input run_last, output ready);
endinterface

/* rtl/dgt_cfg_if.sv */
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on dgt_pkg.
`timescale 1ns / 1ps

interface dgt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dgt_pkg::REG_BITS-1:0]   reg_index;
  logic [dgt_pkg::DATA_BITS-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* rtl/depth_grid_triangulator_top.sv */
// Depth grid triangulator: raster depth pixels in, vertex and face records out.
// Depends on dgt_pkg, dgt_pixel_if, dgt_result_if, dgt_cfg_if.
`timescale 1ns / 1ps

// Usage
//   pixel  : one request per depth pixel in raster order (depth, mask bit).
//   result : vertex record, then face ACD, then face ADB, each only when
//            present; run_last marks the last record a pixel causes.
//   cfg    : register writes, always ready; write only while the block is idle.
// A taken pixel is registered in the cell stage, then in the result bundle.
// Throughput: one pixel per cycle while each pixel causes at most one record
//   and the receiver does not stall; a pixel with more records holds the pipe
//   until its last record is taken. The single result port, one record a cycle, sets this.
// Two line buffer memories (depth, index; 1024 entries) are read when a pixel
//   is taken and written one stage later at the same column; successive
//   pixels always address different columns, so no forwarding is needed.
// Reset: counters, neighbor registers and registers return to their defaults;
//   the line buffers are not cleared (row 0 never uses their contents).
// Stall: a stalled receiver holds the current record; the pixel in flight
//   waits in its stage and ready drops until the record drains.
module depth_grid_triangulator_top (
  input  logic               clk,
  input  logic               rst,
  dgt_pixel_if.sink          pixel,
  dgt_result_if.source       result,
  dgt_cfg_if.sink            cfg
);

  // Configuration registers
  logic [dgt_pkg::WCFG_BITS-1:0]  image_width;
  logic [dgt_pkg::HCFG_BITS-1:0]  image_height;
  logic [dgt_pkg::DEPTH_BITS-1:0] min_depth;
  logic [dgt_pkg::DEPTH_BITS-1:0] max_depth;
  logic [dgt_pkg::DEPTH_BITS-1:0] edge_limit;

  // Frame counters
  logic [dgt_pkg::COL_BITS-1:0]   col_count;
  logic [dgt_pkg::ROW_BITS-1:0]   row_count;
  logic [dgt_pkg::INDEX_BITS-1:0] vertex_count;

  // Line buffers
  logic [dgt_pkg::DEPTH_BITS-1:0] row_depths  [dgt_pkg::MAX_WIDTH];
  logic [dgt_pkg::INDEX_BITS-1:0] row_indices [dgt_pkg::MAX_WIDTH];
  logic [dgt_pkg::DEPTH_BITS-1:0] rd_depth;
  logic [dgt_pkg::INDEX_BITS-1:0] rd_index;

  // Neighbor registers
  logic [dgt_pkg::DEPTH_BITS-1:0] left_depth;
  logic [dgt_pkg::INDEX_BITS-1:0] left_index;
  logic [dgt_pkg::DEPTH_BITS-1:0] upleft_depth;
  logic [dgt_pkg::INDEX_BITS-1:0] upleft_index;

  // Cell stage
  logic                           s1_valid;
  logic [dgt_pkg::DEPTH_BITS-1:0] s1_depth;
  logic [dgt_pkg::INDEX_BITS-1:0] s1_index;
  logic                           s1_vert;
  logic                           s1_interior;
  logic [dgt_pkg::COL_BITS-1:0]   s1_col;
  logic [dgt_pkg::ROW_BITS-1:0]   s1_row;

  // Result bundle
  logic [2:0]                     res_mask;
  logic [dgt_pkg::INDEX_BITS-1:0] res_vidx;
  logic [dgt_pkg::INDEX_BITS-1:0] res_a;
  logic [dgt_pkg::INDEX_BITS-1:0] res_b;
  logic [dgt_pkg::INDEX_BITS-1:0] res_c;
  logic [dgt_pkg::COL_BITS-1:0]   res_col;
  logic [dgt_pkg::ROW_BITS-1:0]   res_row;
  logic [dgt_pkg::DEPTH_BITS-1:0] res_depth;

  logic [dgt_pkg::WCFG_BITS-1:0]  w_eff;
  logic [dgt_pkg::HCFG_BITS-1:0]  h_eff;
  logic                           pixel_fire;
  logic                           is_vert;
  logic [dgt_pkg::INDEX_BITS-1:0] vc_inc;
  logic [dgt_pkg::INDEX_BITS-1:0] new_index;
  logic                           col_wrap;
  logic                           row_wrap;
  logic                           diag_ok;
  logic                           acd_ok;
  logic                           adb_ok;
  logic [2:0]                     s1_mask;
  logic [2:0]                     res_lowest;
  logic                           res_single;
  logic                           res_free;
  logic                           res_fire;
  logic                           s1_adv;

  function automatic logic [dgt_pkg::DEPTH_BITS-1:0] absdiff(
    input logic [dgt_pkg::DEPTH_BITS-1:0] a,
    input logic [dgt_pkg::DEPTH_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= dgt_pkg::RST_IMAGE_WIDTH;
      image_height <= dgt_pkg::RST_IMAGE_HEIGHT;
      min_depth    <= dgt_pkg::RST_MIN_DEPTH;
      max_depth    <= dgt_pkg::RST_MAX_DEPTH;
      edge_limit   <= dgt_pkg::RST_EDGE_LIMIT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        dgt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.wr_data[dgt_pkg::WCFG_BITS-1:0];
        dgt_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.wr_data[dgt_pkg::HCFG_BITS-1:0];
        dgt_pkg::REG_MIN_DEPTH:    min_depth    <= cfg.wr_data;
        dgt_pkg::REG_MAX_DEPTH:    max_depth    <= cfg.wr_data;
        dgt_pkg::REG_EDGE_LIMIT:   edge_limit   <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (image_width < dgt_pkg::WCFG_BITS'(2))
      w_eff = dgt_pkg::WCFG_BITS'(2);
    else if (image_width > dgt_pkg::WCFG_BITS'(dgt_pkg::MAX_WIDTH))
      w_eff = dgt_pkg::WCFG_BITS'(dgt_pkg::MAX_WIDTH);
    else
      w_eff = image_width;
    if (image_height < dgt_pkg::HCFG_BITS'(2))
      h_eff = dgt_pkg::HCFG_BITS'(2);
    else if (image_height > dgt_pkg::HCFG_BITS'(dgt_pkg::MAX_ROWS))
      h_eff = dgt_pkg::HCFG_BITS'(dgt_pkg::MAX_ROWS);
    else
      h_eff = image_height;
  end

  // Vertex test and raster position
  assign pixel_fire = pixel.valid && pixel.ready;
  assign is_vert    = pixel.in_mask && (pixel.depth_value >= min_depth)
                      && (pixel.depth_value <= max_depth);
  assign vc_inc     = vertex_count + dgt_pkg::INDEX_BITS'(1);
  assign new_index  = is_vert ? vc_inc : '0;
  assign col_wrap   = ({1'b0, col_count} + dgt_pkg::WCFG_BITS'(1)) >= w_eff;
  assign row_wrap   = ({1'b0, row_count} + dgt_pkg::HCFG_BITS'(1)) >= h_eff;

  // Advance counters on each pixel request
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count    <= '0;
      row_count    <= '0;
      vertex_count <= '0;
    end else if (pixel_fire) begin
      if (col_wrap) begin
        col_count <= '0;
        if (row_wrap) begin
          row_count    <= '0;
          vertex_count <= '0;
        end else begin
          row_count    <= row_count + dgt_pkg::ROW_BITS'(1);
          vertex_count <= is_vert ? vc_inc : vertex_count;
        end
      end else begin
        col_count    <= col_count + dgt_pkg::COL_BITS'(1);
        vertex_count <= is_vert ? vc_inc : vertex_count;
      end
    end
  end

  // Line buffer for depths: read on request, write back from the cell stage
  always_ff @(posedge clk) begin
    if (s1_adv)
      row_depths[s1_col] <= s1_depth;
    if (pixel_fire)
      rd_depth <= row_depths[col_count];
  end

  // Line buffer for vertex indices
  always_ff @(posedge clk) begin
    if (s1_adv)
      row_indices[s1_col] <= s1_index;
    if (pixel_fire)
      rd_index <= row_indices[col_count];
  end

  // Cell stage control
  assign s1_adv      = s1_valid && res_free;
  assign pixel.ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (pixel_fire)
      s1_valid <= 1'b1;
    else if (s1_adv)
      s1_valid <= 1'b0;
  end

  // Hold the pixel for the cell test
  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      s1_depth    <= pixel.depth_value;
      s1_index    <= new_index;
      s1_vert     <= is_vert;
      s1_interior <= (col_count != '0) && (row_count != '0);
      s1_col      <= col_count;
      s1_row      <= row_count;
    end
  end

  // Test the 2x2 cell: A up-left, B up (line buffer), C left, D current
  always_comb begin
    diag_ok = s1_interior && (upleft_index != '0) && (s1_index != '0)
              && (absdiff(upleft_depth, s1_depth) <= edge_limit);
    acd_ok  = diag_ok && (left_index != '0)
              && (absdiff(upleft_depth, left_depth) <= edge_limit)
              && (absdiff(s1_depth, left_depth) <= edge_limit);
    adb_ok  = diag_ok && (rd_index != '0)
              && (absdiff(upleft_depth, rd_depth) <= edge_limit)
              && (absdiff(s1_depth, rd_depth) <= edge_limit);
    s1_mask = {adb_ok, acd_ok, s1_vert};
  end

  // Shift the neighbor window as the pixel leaves the cell stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_depth   <= '0;
      left_index   <= '0;
      upleft_depth <= '0;
      upleft_index <= '0;
    end else if (s1_adv) begin
      left_depth   <= s1_depth;
      left_index   <= s1_index;
      upleft_depth <= rd_depth;
      upleft_index <= rd_index;
    end
  end

  // Result bundle bookkeeping
  assign res_lowest = res_mask & (~res_mask + 3'd1);
  assign res_single = (res_mask & (res_mask - 3'd1)) == 3'd0;
  assign res_fire   = result.valid && result.ready;
  assign res_free   = (res_mask == 3'd0) || (res_single && result.ready);

  always_ff @(posedge clk) begin
    if (rst)
      res_mask <= 3'd0;
    else if (s1_adv)
      res_mask <= s1_mask;
    else if (res_fire)
      res_mask <= res_mask & ~res_lowest;
  end

  // Load the pixel's records
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_vidx  <= s1_index;
      res_a     <= upleft_index;
      res_b     <= rd_index;
      res_c     <= left_index;
      res_col   <= s1_col;
      res_row   <= s1_row;
      res_depth <= s1_depth;
    end
  end

  // Drive the pending record, lowest slot first
  assign result.valid    = res_mask != 3'd0;
  assign result.run_last = res_single;

  always_comb begin
    result.item_kind = dgt_pkg::KIND_VERTEX;
    result.index_a   = '0;
    result.index_b   = '0;
    result.index_c   = '0;
    result.pixel_col = '0;
    result.pixel_row = '0;
    result.depth_out = '0;
    case (res_lowest)
      dgt_pkg::SLOT_VERTEX: begin
        result.index_a   = res_vidx;
        result.pixel_col = res_col;
        result.pixel_row = res_row;
        result.depth_out = res_depth;
      end
      dgt_pkg::SLOT_ACD: begin
        result.item_kind = dgt_pkg::KIND_FACE;
        result.index_a   = res_a;
        result.index_b   = res_c;
        result.index_c   = res_vidx;
      end
      dgt_pkg::SLOT_ADB: begin
        result.item_kind = dgt_pkg::KIND_FACE;
        result.index_a   = res_a;
        result.index_b   = res_vidx;
        result.index_c   = res_b;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Line buffer write and read never hit the same column in one cycle
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && pixel_fire |-> s1_col != col_count)
    else $error("line buffer read and write collide");

  // Faces only come from cells away from the first row and column
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && (acd_ok || adb_ok) |-> s1_col != '0 && s1_row != '0)
    else $error("face emitted on frame border");

  // Vertex numbering restarts after the last pixel of a frame
  assert property (@(posedge clk) disable iff (rst)
    pixel_fire && col_wrap && row_wrap |=> vertex_count == '0)
    else $error("vertex count not cleared at frame end");

  // A new bundle loads only once the previous one drains
  assert property (@(posedge clk) disable iff (rst)
    s1_adv |-> res_mask == 3'd0 || (res_single && res_fire))
    else $error("result bundle overwritten");
`endif

endmodule

/* sim/tb_depth_grid_triangulator_top.sv */
// Testbench for depth_grid_triangulator_top: streams depth pixels, predicts the
// vertex and face records of every request and checks them in order.
// Depends on dgt_pkg, dgt_pixel_if, dgt_result_if, dgt_cfg_if and the block.
`timescale 1ns / 1ps

module tb_depth_grid_triangulator_top;

  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MODE_ITEMS    = 60;
  localparam int MAX_PRINTS    = 50;

  typedef struct packed {
    logic                           kind;
    logic [dgt_pkg::INDEX_BITS-1:0] idx_a;
    logic [dgt_pkg::INDEX_BITS-1:0] idx_b;
    logic [dgt_pkg::INDEX_BITS-1:0] idx_c;
    logic [dgt_pkg::COL_BITS-1:0]   col;
    logic [dgt_pkg::ROW_BITS-1:0]   row;
    logic [dgt_pkg::DEPTH_BITS-1:0] depth;
    logic                           last;
  } mesh_rec_t;

  logic clk;
  logic rst;

  dgt_pixel_if  pixel_ch();
  dgt_result_if result_ch();
  dgt_cfg_if    cfg_ch();

  depth_grid_triangulator_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Register copies and mesh state as the block should hold them
  logic [dgt_pkg::WCFG_BITS-1:0]  reg_width;
  logic [dgt_pkg::HCFG_BITS-1:0]  reg_height;
  logic [dgt_pkg::DEPTH_BITS-1:0] reg_min;
  logic [dgt_pkg::DEPTH_BITS-1:0] reg_max;
  logic [dgt_pkg::DEPTH_BITS-1:0] reg_edge;
  logic [dgt_pkg::DEPTH_BITS-1:0] line_depth [dgt_pkg::MAX_WIDTH];
  logic [dgt_pkg::INDEX_BITS-1:0] line_index [dgt_pkg::MAX_WIDTH];
  logic [dgt_pkg::DEPTH_BITS-1:0] left_depth;
  logic [dgt_pkg::DEPTH_BITS-1:0] diag_depth;
  logic [dgt_pkg::INDEX_BITS-1:0] left_index;
  logic [dgt_pkg::INDEX_BITS-1:0] diag_index;
  logic [dgt_pkg::INDEX_BITS-1:0] vertex_total;
  int unsigned                    col_pos;
  int unsigned                    row_pos;

  mesh_rec_t   awaited_mesh_recs[$];
  int unsigned err_count      = 0;
  int unsigned pixels_sent    = 0;
  int unsigned src_gap_pct    = 20;
  int unsigned sink_stall_pct = 69;
  int unsigned quiet_cycles   = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void clear_mesh_state();
    reg_width  = dgt_pkg::RST_IMAGE_WIDTH;
    reg_height = dgt_pkg::RST_IMAGE_HEIGHT;
    reg_min    = dgt_pkg::RST_MIN_DEPTH;
    reg_max    = dgt_pkg::RST_MAX_DEPTH;
    reg_edge   = dgt_pkg::RST_EDGE_LIMIT;
    foreach (line_depth[i]) begin
      line_depth[i] = '0;
      line_index[i] = '0;
    end
    left_depth   = '0;
    diag_depth   = '0;
    left_index   = '0;
    diag_index   = '0;
    vertex_total = '0;
    col_pos      = 0;
    row_pos      = 0;
  endfunction

  function automatic void apply_reg(input logic [dgt_pkg::REG_BITS-1:0] idx,
                                    input logic [dgt_pkg::DATA_BITS-1:0] data);
    case (idx)
      dgt_pkg::REG_IMAGE_WIDTH:  reg_width  = data[dgt_pkg::WCFG_BITS-1:0];
      dgt_pkg::REG_IMAGE_HEIGHT: reg_height = data[dgt_pkg::HCFG_BITS-1:0];
      dgt_pkg::REG_MIN_DEPTH:    reg_min    = data[dgt_pkg::DEPTH_BITS-1:0];
      dgt_pkg::REG_MAX_DEPTH:    reg_max    = data[dgt_pkg::DEPTH_BITS-1:0];
      dgt_pkg::REG_EDGE_LIMIT:   reg_edge   = data[dgt_pkg::DEPTH_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [dgt_pkg::DEPTH_BITS-1:0] depth_step(
    input logic [dgt_pkg::DEPTH_BITS-1:0] p,
    input logic [dgt_pkg::DEPTH_BITS-1:0] q
  );
    return (p > q) ? p - q : q - p;
  endfunction

  function automatic void push_rec(input logic kind,
                                   input logic [dgt_pkg::INDEX_BITS-1:0] a,
                                   input logic [dgt_pkg::INDEX_BITS-1:0] b,
                                   input logic [dgt_pkg::INDEX_BITS-1:0] c,
                                   input int unsigned col, input int unsigned row,
                                   input logic [dgt_pkg::DEPTH_BITS-1:0] d);
    mesh_rec_t r;
    r.kind  = kind;
    r.idx_a = a;
    r.idx_b = b;
    r.idx_c = c;
    r.col   = dgt_pkg::COL_BITS'(col);
    r.row   = dgt_pkg::ROW_BITS'(row);
    r.depth = d;
    r.last  = 1'b0;
    awaited_mesh_recs.push_back(r);
  endfunction

  // Work out the records one accepted pixel causes and advance the mesh state
  function automatic void mesh_records_for_pixel(input logic [dgt_pkg::DEPTH_BITS-1:0] d,
                                                 input logic m);
    int unsigned                    w;
    int unsigned                    h;
    int unsigned                    x;
    int unsigned                    y;
    int unsigned                    n;
    logic [dgt_pkg::INDEX_BITS-1:0] idx;
    logic [dgt_pkg::INDEX_BITS-1:0] up_index;
    logic [dgt_pkg::DEPTH_BITS-1:0] up_depth;
    w   = reg_width;
    h   = reg_height;
    x   = col_pos;
    y   = row_pos;
    n   = 0;
    idx = '0;
    if (w < 2) w = 2;
    if (w > dgt_pkg::MAX_WIDTH) w = dgt_pkg::MAX_WIDTH;
    if (h < 2) h = 2;
    if (h > dgt_pkg::MAX_ROWS) h = dgt_pkg::MAX_ROWS;

    // new vertex when inside the mask and the depth window
    if (m && d >= reg_min && d <= reg_max) begin
      vertex_total = vertex_total + 1'b1;
      idx = vertex_total;
      push_rec(dgt_pkg::KIND_VERTEX, idx, '0, '0, x, y, d);
      n++;
    end

    up_depth = line_depth[x];
    up_index = line_index[x];

    // close the cell whose bottom-right corner is this pixel
    if (x >= 1 && y >= 1 && diag_index != 0 && idx != 0 &&
        depth_step(diag_depth, d) <= reg_edge) begin
      if (left_index != 0 && depth_step(diag_depth, left_depth) <= reg_edge &&
          depth_step(d, left_depth) <= reg_edge) begin
        push_rec(dgt_pkg::KIND_FACE, diag_index, left_index, idx, 0, 0, '0);
        n++;
      end
      if (up_index != 0 && depth_step(diag_depth, up_depth) <= reg_edge &&
          depth_step(d, up_depth) <= reg_edge) begin
        push_rec(dgt_pkg::KIND_FACE, diag_index, idx, up_index, 0, 0, '0);
        n++;
      end
    end
    if (n > 0) awaited_mesh_recs[awaited_mesh_recs.size() - 1].last = 1'b1;

    diag_depth    = up_depth;
    diag_index    = up_index;
    left_depth    = d;
    left_index    = idx;
    line_depth[x] = d;
    line_index[x] = idx;

    // wrap column, row and vertex numbering at the frame edges
    if (x + 1 >= w) begin
      col_pos = 0;
      if (y + 1 >= h) begin
        row_pos      = 0;
        vertex_total = '0;
      end else begin
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, wanted %0h", name, got, want));
  endtask

  // Send one pixel request, idling first at random; valid stays high afterwards
  task automatic send_pixel(input logic [dgt_pkg::DEPTH_BITS-1:0] d, input logic m);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      pixel_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_gap_pct);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.depth_value <= d;
    pixel_ch.in_mask     <= m;
    do @(posedge clk); while (!pixel_ch.ready);
    mesh_records_for_pixel(d, m);
    pixels_sent++;
  endtask

  // Drop valid and hold until every awaited record has arrived and the pipe is empty
  task automatic wait_drained();
    pixel_ch.valid <= 1'b0;
    while (awaited_mesh_recs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; hold valid when another write follows directly
  task automatic write_reg(input logic [dgt_pkg::REG_BITS-1:0] idx,
                           input logic [dgt_pkg::DATA_BITS-1:0] data,
                           input logic keep_valid);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, data);
    if (!keep_valid) cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure_all(input logic [dgt_pkg::DATA_BITS-1:0] w,
                               input logic [dgt_pkg::DATA_BITS-1:0] h,
                               input logic [dgt_pkg::DATA_BITS-1:0] mn,
                               input logic [dgt_pkg::DATA_BITS-1:0] mx,
                               input logic [dgt_pkg::DATA_BITS-1:0] lim);
    wait_drained();
    write_reg(dgt_pkg::REG_IMAGE_WIDTH,  w,   1'b1);
    write_reg(dgt_pkg::REG_IMAGE_HEIGHT, h,   1'b1);
    write_reg(dgt_pkg::REG_MIN_DEPTH,    mn,  1'b1);
    write_reg(dgt_pkg::REG_MAX_DEPTH,    mx,  1'b1);
    write_reg(dgt_pkg::REG_EDGE_LIMIT,   lim, 1'b0);
  endtask

  function automatic int unsigned frame_base();
    if (reg_min <= reg_max) return $urandom_range(reg_min, reg_max);
    return $urandom_range(0, 65535);
  endfunction

  // Mostly smooth surface around base, now and then a fully random pixel
  task automatic send_random_pixel(input int unsigned base);
    int unsigned spread;
    int unsigned v;
    if ($urandom_range(0, 9) == 0) begin
      send_pixel(dgt_pkg::DEPTH_BITS'($urandom), 1'($urandom_range(0, 1)));
    end else begin
      spread = (reg_edge > 3000) ? 3000 : reg_edge + 2;
      v = base + $urandom_range(0, 2 * spread);
      v = (v < spread) ? 0 : v - spread;
      if (v > 65535) v = 65535;
      send_pixel(dgt_pkg::DEPTH_BITS'(v), $urandom_range(0, 9) != 0);
    end
  endtask

  task automatic send_rest_of_frame(input int unsigned base);
    do send_random_pixel(base); while (col_pos != 0 || row_pos != 0);
  endtask

  task automatic configure_random();
    logic [dgt_pkg::DATA_BITS-1:0] w;
    logic [dgt_pkg::DATA_BITS-1:0] h;
    logic [dgt_pkg::DATA_BITS-1:0] mn;
    logic [dgt_pkg::DATA_BITS-1:0] mx;
    logic [dgt_pkg::DATA_BITS-1:0] lim;
    w   = dgt_pkg::DATA_BITS'($urandom_range(2, 6));
    h   = dgt_pkg::DATA_BITS'($urandom_range(2, 5));
    mn  = 16'd0;
    mx  = 16'hFFFF;
    lim = dgt_pkg::DATA_BITS'($urandom_range(0, 2000));
    case ($urandom_range(0, 5))
      1: lim = 16'd0;
      2: begin
        lim = 16'hFFFF;
        mn  = dgt_pkg::DATA_BITS'($urandom_range(0, 30000));
        mx  = mn + dgt_pkg::DATA_BITS'($urandom_range(0, 35535));
      end
      3: begin
        // empty depth window
        mn = dgt_pkg::DATA_BITS'($urandom_range(1, 65535));
        mx = dgt_pkg::DATA_BITS'($urandom_range(0, mn - 1));
      end
      4: begin
        mn = dgt_pkg::DATA_BITS'($urandom_range(0, 60000));
        mx = mn + dgt_pkg::DATA_BITS'($urandom_range(0, 5000));
      end
      5: begin
        // sizes below two act as two
        w = dgt_pkg::DATA_BITS'($urandom_range(0, 1));
        h = dgt_pkg::DATA_BITS'($urandom_range(0, 1));
      end
      default: ;
    endcase
    configure_all(w, h, mn, mx, lim);
  endtask

  task automatic test_reset_values();
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h1234, 1'b0);
  endtask

  // Shrink width and height in row 0 while the column is past the new width
  task automatic test_midframe_wrap();
    wait_drained();
    write_reg(dgt_pkg::REG_IMAGE_WIDTH,  16'd1, 1'b1);
    write_reg(dgt_pkg::REG_IMAGE_HEIGHT, 16'd0, 1'b0);
    send_pixel(16'd100, 1'b1);
    send_pixel(16'd100, 1'b1);
    send_pixel(16'd200, 1'b1);
  endtask

  task automatic test_face_cases();
    configure_all(16'd2, 16'd2, 16'd0, 16'hFFFF, 16'd300);
    // both faces, diagonal step exactly at the limit
    send_pixel(16'd1000, 1'b1);
    send_pixel(16'd1200, 1'b1);
    send_pixel(16'd1100, 1'b1);
    send_pixel(16'd1300, 1'b1);
    // left corner too far, upper corner outside the mask
    send_pixel(16'd1000, 1'b1);
    send_pixel(16'd1000, 1'b0);
    send_pixel(16'd1301, 1'b1);
    send_pixel(16'd1000, 1'b1);
    // up-left corner missing
    send_pixel(16'd500, 1'b0);
    send_pixel(16'd500, 1'b1);
    send_pixel(16'd500, 1'b1);
    send_pixel(16'd500, 1'b1);
  endtask

  task automatic test_depth_window();
    configure_all(16'd2, 16'd2, 16'd1000, 16'd2000, 16'd5000);
    send_pixel(16'd999,  1'b1);
    send_pixel(16'd1000, 1'b1);
    send_pixel(16'd2000, 1'b1);
    send_pixel(16'd2001, 1'b1);
  endtask

  // Widest and tallest settings, then cut back mid-frame
  task automatic test_widest_frame();
    int unsigned base;
    configure_all(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1500);
    base = frame_base();
    repeat (24) send_random_pixel(base);
    wait_drained();
    write_reg(dgt_pkg::REG_IMAGE_WIDTH,  16'd3, 1'b1);
    write_reg(dgt_pkg::REG_IMAGE_HEIGHT, 16'd2, 1'b0);
    send_rest_of_frame(base);
  endtask

  task automatic test_random_frames(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned start;
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    start          = pixels_sent;
    while (pixels_sent - start < MODE_ITEMS) begin
      configure_random();
      repeat ($urandom_range(1, 2)) send_rest_of_frame(frame_base());
    end
  endtask

  // Drive the result ready with random stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Compare each accepted record with the oldest awaited one
  always @(posedge clk) begin : check_results
    mesh_rec_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_mesh_recs.size() == 0) begin
        report_mismatch("record arrived while none was awaited");
      end else begin
        want = awaited_mesh_recs.pop_front();
        check_field("item_kind", result_ch.item_kind, want.kind);
        check_field("index_a",   result_ch.index_a,   want.idx_a);
        check_field("index_b",   result_ch.index_b,   want.idx_b);
        check_field("index_c",   result_ch.index_c,   want.idx_c);
        check_field("pixel_col", result_ch.pixel_col, want.col);
        check_field("pixel_row", result_ch.pixel_row, want.row);
        check_field("depth_out", result_ch.depth_out, want.depth);
        check_field("run_last",  result_ch.run_last,  want.last);
      end
    end
  end

  // Abort when no request moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                  <= 1'b1;
    pixel_ch.valid       <= 1'b0;
    pixel_ch.depth_value <= '0;
    pixel_ch.in_mask     <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= dgt_pkg::REG_IMAGE_WIDTH;
    cfg_ch.wr_data       <= '0;
    clear_mesh_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_midframe_wrap();
    test_face_cases();
    test_depth_window();
    test_widest_frame();
    test_random_frames(20, 69);
    test_random_frames(69, 20);
    test_random_frames(0, 0);

    wait_drained();
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dgt_pkg.sv
rtl/dgt_pixel_if.sv
rtl/dgt_result_if.sv
rtl/dgt_cfg_if.sv
rtl/depth_grid_triangulator_top.sv
sim/tb_depth_grid_triangulator_top.sv
